@@ hdl/sha256_pkg.sv @@
// SHA-256 stream hasher: shared types, constants and round functions.
// No dependencies; used by every module under hdl.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       final_req;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Front-to-back command: a word of the block ready, or an end request.
    typedef struct packed {
        logic [31:0] word;     // big-endian message word
        logic [3:0]  widx;     // word position in the block
        logic        blk_end;  // last word of a block: compress after it
        logic        digest;   // after compressing, emit digest and restart
    } cmd_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_ROUND,
        BK_ADD,
        BK_EMIT
    } bk_state_t;

    typedef enum logic [1:0] {
        FR_BYTES,
        FR_PAD,
        FR_LEN_HI,
        FR_LEN_LO
    } fr_state_t;

    localparam logic [255:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ hdl/sha256_stream_hasher_core.sv @@
// SHA-256 stream hasher top level: front, command queue and back.
// Depends on sha256_pkg, sha256_front, sha256_fifo, sha256_back.
//
//  channel | direction | handshake        | payload
//  in      | request in  | in_valid/in_stall  | in_item_t
//  out     | request out | out_valid/out_stall| out_item_t
//
// A byte request is taken each cycle while the queue has room and no padding
// is under way; every fourth byte pushes one word. During the 64 rounds of a
// block the back takes no words, so the queue and the front register fill after
// 20 bytes and input stalls; sustained throughput is set by the single round
// unit. A final request adds 3 to 18 pad and length words, up to two blocks and
// eight digest words. Reset restores the initial hash value at once.
module sha256_stream_hasher_core #(
    parameter int QDEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sha256_pkg::in_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha256_pkg::out_item_t out_item
);
    import sha256_pkg::*;

    cmd_t f_cmd, b_cmd;
    logic f_valid, f_stall, b_valid, b_stall;

    sha256_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
    );

    sha256_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall),
        .wr_data(f_cmd), .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_cmd)
    );

    sha256_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(b_valid), .cmd_stall(b_stall),
        .cmd(b_cmd), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item)
    );

endmodule

@@ hdl/sha256_front.sv @@
// SHA-256 front: packs bytes into words, counts length, builds padding.
// Depends on sha256_pkg.
module sha256_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sha256_pkg::in_item_t in_item,
    output logic                 cmd_valid,
    input  logic                 cmd_stall,
    output sha256_pkg::cmd_t     cmd
);
    import sha256_pkg::*;

    fr_state_t   state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [60:0] len_reg, len_next;
    logic [23:0] part_reg, part_next;     // earlier bytes of the current word
    logic        cvalid_reg, cvalid_next;
    cmd_t        cmd_reg, cmd_next;
    logic        free;
    logic [1:0]  lane;
    logic [3:0]  widx;
    logic [31:0] word;
    logic [63:0] bit_len;

    assign free      = !cvalid_reg || !cmd_stall;
    assign lane      = count_reg[1:0];
    assign widx      = count_reg[5:2];
    assign bit_len   = {count_reg, 3'b000};
    assign in_stall  = !(state_reg == FR_BYTES && free);
    assign cmd_valid = cvalid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        part_next   = part_reg;
        cvalid_next = cvalid_reg && cmd_stall;
        cmd_next    = cmd_reg;
        word        = '0;
        case (state_reg)
            FR_BYTES:
            begin
                if (in_valid && free)
                begin
                    if (in_item.has_byte)
                    begin
                        count_next = count_reg + 61'd1;
                        case (lane)
                            2'd0: part_next[23:16] = in_item.data_byte;
                            2'd1: part_next[15:8]  = in_item.data_byte;
                            2'd2: part_next[7:0]   = in_item.data_byte;
                            default:
                            begin
                                cvalid_next = 1'b1;
                                cmd_next = '{word: {part_reg, in_item.data_byte},
                                             widx: widx, blk_end: widx == 4'd15,
                                             digest: 1'b0};
                            end
                        endcase
                    end
                    if (in_item.final_req)
                        state_next = FR_PAD;
                end
            end
            FR_PAD:
            begin
                // emit the word holding 0x80, then zero words up to word 13
                if (free)
                begin
                    case (lane)
                        2'd0: word = {PAD_BYTE, 24'h0};
                        2'd1: word = {part_reg[23:16], PAD_BYTE, 16'h0};
                        2'd2: word = {part_reg[23:8], PAD_BYTE, 8'h0};
                        default: word = {part_reg, PAD_BYTE};
                    endcase
                    // pointer has moved past the tail: 0x80 already sent
                    if (count_reg[5:0] != len_reg[5:0])
                        word = '0;
                    cvalid_next = 1'b1;
                    cmd_next = '{word: word, widx: widx, blk_end: widx == 4'd15,
                                 digest: 1'b0};
                    // reuse count low bits as pad pointer; length kept in upper
                    part_next = '0;
                    count_next[1:0] = 2'd0;
                    count_next[5:2] = widx + 4'd1;
                    if (widx == 4'd13)
                        state_next = FR_LEN_HI;
                end
            end
            FR_LEN_HI:
            begin
                if (free)
                begin
                    cvalid_next = 1'b1;
                    cmd_next = '{word: bit_len[63:32], widx: 4'd14, blk_end: 1'b0,
                                 digest: 1'b0};
                    state_next = FR_LEN_LO;
                end
            end
            default:
            begin
                if (free)
                begin
                    cvalid_next = 1'b1;
                    cmd_next = '{word: bit_len[31:0], widx: 4'd15, blk_end: 1'b1,
                                 digest: 1'b1};
                    state_next = FR_BYTES;
                    count_next = '0;
                    part_next  = '0;
                end
            end
        endcase
    end

    // Length is frozen once padding starts; only the fill pointer moves.
    always_comb
    begin
        len_next = len_reg;
        if (state_reg == FR_BYTES)
            len_next = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FR_BYTES;
            count_reg  <= '0;
            cvalid_reg <= 1'b0;
            part_reg   <= '0;
            len_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cvalid_reg <= cvalid_next;
            part_reg   <= part_next;
            len_reg    <= len_next;
            if (state_reg == FR_LEN_HI || state_reg == FR_LEN_LO)
                count_reg <= (state_next == FR_BYTES) ? '0 : len_reg;
            else if (state_reg == FR_PAD && state_next == FR_LEN_HI)
                count_reg <= len_reg;
            else if (state_reg == FR_PAD)
                count_reg <= {len_reg[60:6], count_next[5:0]};
            else
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ hdl/sha256_fifo.sv @@
// Short command queue between front and back of the SHA-256 hasher.
// Depends on sha256_pkg.
module sha256_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_stall,
    input  sha256_pkg::cmd_t   wr_data,
    output logic               rd_valid,
    input  logic               rd_stall,
    output sha256_pkg::cmd_t   rd_data
);
    import sha256_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_stall = cnt_reg == (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign wr       = wr_valid && !wr_stall;
    assign rd       = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

endmodule

@@ hdl/sha256_back.sv @@
// SHA-256 back: message schedule, one round per cycle, chain and digest out.
// Depends on sha256_pkg.
module sha256_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  sha256_pkg::cmd_t      cmd,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sha256_pkg::out_item_t out_item
);
    import sha256_pkg::*;

    bk_state_t    state_reg, state_next;
    logic [31:0]  w_reg [16];    // 16-word sliding schedule window
    logic [255:0] h_reg, v_reg;  // chain value and working variables
    logic [5:0]   t_reg;
    logic         dig_reg;
    logic [2:0]   oi_reg;
    logic         ov_reg;
    out_item_t    oitem_reg;
    logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, wn, s0, s1;
    logic         take, emit_free;

    assign {a, b, c, d, e, f, g, hh} = v_reg;
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wn = w_reg[0] + w_reg[9] + s0 + s1;
    assign t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + round_k(t_reg) + w_reg[0];
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

    assign cmd_stall = state_reg != BK_LOAD;
    assign take      = cmd_valid && state_reg == BK_LOAD;
    assign emit_free = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_item  = oitem_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD:  if (take && cmd.blk_end) state_next = BK_ROUND;
            BK_ROUND: if (t_reg == 6'd63) state_next = BK_ADD;
            BK_ADD:   state_next = dig_reg ? BK_EMIT : BK_LOAD;
            BK_EMIT:  if (emit_free && oi_reg == 3'd7) state_next = BK_LOAD;
            default:  state_next = BK_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
            h_reg     <= IV;
            t_reg     <= '0;
            dig_reg   <= 1'b0;
            oi_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_EMIT && emit_free)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                BK_LOAD:
                begin
                    if (take && cmd.blk_end)
                    begin
                        dig_reg <= cmd.digest;
                        t_reg   <= '0;
                    end
                end
                BK_ROUND: t_reg <= t_reg + 6'd1;
                BK_ADD:
                begin
                    h_reg  <= {h_reg[255:224] + a, h_reg[223:192] + b,
                               h_reg[191:160] + c, h_reg[159:128] + d,
                               h_reg[127:96] + e, h_reg[95:64] + f,
                               h_reg[63:32] + g, h_reg[31:0] + hh};
                    oi_reg <= '0;
                end
                BK_EMIT:
                begin
                    if (emit_free)
                    begin
                        oi_reg <= oi_reg + 3'd1;
                        if (oi_reg == 3'd7)
                            h_reg <= IV;
                        else
                            h_reg <= {h_reg[223:0], 32'h0};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_EMIT && emit_free)
            oitem_reg <= '{digest_word: h_reg[255:224], word_index: oi_reg,
                           last_word: oi_reg == 3'd7};
        if (take)
            w_reg[cmd.widx] <= cmd.word;
        if (take && cmd.blk_end)
            v_reg <= h_reg;
        if (state_reg == BK_ROUND)
        begin
            v_reg <= {t1 + t2, a, b, c, d + t1, e, f, g};
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
        end
    end

endmodule
